// ===== design/orws_pkg.sv =====
package orws_pkg;

    localparam int ROM_BITS     = 64;
    localparam int POS_W        = 7;
    localparam int FAMILY_LIMIT = 9;
    localparam logic [7:0] CRC_POLY = 8'h8C;   // x^8+x^5+x^4+1, reflected

    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    typedef enum logic [1:0] {
        ACT_RESTART = 2'd0,
        ACT_BEGIN   = 2'd1,
        ACT_PAIR    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        OP_RESTART,
        OP_BEGIN,
        OP_PAIR,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        ST_WRITE   = 3'd0,
        ST_COMMAND = 3'd1,
        ST_FOUND   = 3'd2,
        ST_FAILED  = 3'd3,
        ST_DONE    = 3'd4,
        ST_RESTART = 3'd5
    } status_t;

    typedef struct packed {
        op_t  op;
        logic presence;
        logic true_bit;
        logic complement_bit;
    } cmd_t;

    // Dallas CRC-8, one byte, LSB first
    function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] data_in);
        logic [7:0] crc;
        logic [7:0] data;
        crc  = crc_in;
        data = data_in;
        for (int i = 0; i < 8; i++)
        begin
            if ((crc[0] ^ data[0]) == 1'b1)
                crc = (crc >> 1) ^ CRC_POLY;
            else
                crc = crc >> 1;
            data = data >> 1;
        end
        return crc;
    endfunction

endpackage

// ===== design/onewire_rom_search_top.sv =====
// 1-Wire search-ROM decision engine. Send a restart word, then a begin-pass word with the
// reset presence result, then one word per address bit carrying the true and complement
// bits read from the bus; each input word yields exactly one output word (status plus the
// direction bit to write, and the ROM code, family discrepancy and last-device flag when a
// device is found). Throughput is one word per clock while the output is not stalled: a
// two-word input queue feeds the search engine, whose state update and byte CRC are
// combinational, and the registered output stage takes a new result as the previous one is
// accepted. A word passes the input queue register and then the output register.
module onewire_rom_search_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // presence, true_bit, complement_bit, zero pad
    input  logic [orws_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [orws_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // write_bit, rom_code[63:0], family_discrepancy[6:0], last_device, zero pad
    output logic [orws_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [orws_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import orws_pkg::*;

    logic head_valid;
    cmd_t head_cmd;
    logic head_pop;

    orws_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_pop      (head_pop)
    );

    orws_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .head_pop      (head_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== design/orws_front.sv =====
module orws_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // presence, true_bit, complement_bit, zero pad
    input  logic [orws_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action
    input  logic [orws_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                               head_valid,
    output orws_pkg::cmd_t                     head_cmd,
    input  logic                               head_pop
);
    import orws_pkg::*;

    cmd_t       queue_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push;
    logic       pop;

    always_comb
    begin
        unique case (action_t'(s_axis_tuser))
            ACT_RESTART: cmd_in.op = OP_RESTART;
            ACT_BEGIN:   cmd_in.op = OP_BEGIN;
            ACT_PAIR:    cmd_in.op = OP_PAIR;
            default:     cmd_in.op = OP_NONE;
        endcase
        cmd_in.presence       = s_axis_tdata[0];
        cmd_in.true_bit       = s_axis_tdata[1];
        cmd_in.complement_bit = s_axis_tdata[2];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign head_valid    = (count_reg != 2'd0);
    assign head_cmd      = queue_reg[rd_ptr_reg];
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

// ===== design/orws_back.sv =====
module orws_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  orws_pkg::cmd_t                     head_cmd,
    output logic                               head_pop,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // write_bit, rom_code[63:0], family_discrepancy[6:0], last_device, zero pad
    output logic [orws_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [orws_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import orws_pkg::*;

    logic [ROM_BITS-1:0] rom_reg, rom_next;
    logic [POS_W-1:0]    last_disc_reg, last_disc_next;
    logic [POS_W-1:0]    fam_reg, fam_next;
    logic                last_dev_reg, last_dev_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [POS_W-1:0]    plz_reg, plz_next;
    logic [7:0]          crc_reg, crc_next;
    logic                active_reg, active_next;

    logic                out_valid_reg;
    status_t             out_status_reg, status_c;
    logic                out_wbit_reg, wbit_c;
    logic [ROM_BITS-1:0] out_rom_reg, rom_c;
    logic [POS_W-1:0]    out_fam_reg, fam_c;
    logic                out_last_reg, last_c;

    logic                take;
    logic [POS_W-1:0]    pos_c;
    logic [POS_W-1:0]    pos_m1;
    logic [5:0]          idx;
    logic                dir;

    assign head_pop = head_valid && (!out_valid_reg || m_axis_tready);
    assign take     = head_pop;

    always_comb
    begin
        rom_next       = rom_reg;
        last_disc_next = last_disc_reg;
        fam_next       = fam_reg;
        last_dev_next  = last_dev_reg;
        pos_next       = pos_reg;
        plz_next       = plz_reg;
        crc_next       = crc_reg;
        active_next    = active_reg;
        status_c       = ST_FAILED;
        wbit_c         = 1'b0;
        rom_c          = '0;
        fam_c          = '0;
        last_c         = 1'b0;
        dir            = 1'b0;

        if (pos_reg == '0 || pos_reg > POS_W'(ROM_BITS))
            pos_c = POS_W'(1);
        else
            pos_c = pos_reg;
        pos_m1 = pos_c - POS_W'(1);
        idx    = pos_m1[5:0];

        unique case (head_cmd.op)
            OP_RESTART:
            begin
                last_disc_next = '0;
                fam_next       = '0;
                last_dev_next  = 1'b0;
                active_next    = 1'b0;
                status_c       = ST_RESTART;
            end
            OP_BEGIN:
            begin
                active_next = 1'b0;
                if (last_dev_reg)
                begin
                    last_disc_next = '0;
                    fam_next       = '0;
                    last_dev_next  = 1'b0;
                    status_c       = ST_DONE;
                end
                else if (!head_cmd.presence)
                begin
                    last_disc_next = '0;
                    fam_next       = '0;
                    last_dev_next  = 1'b0;
                    status_c       = ST_FAILED;
                end
                else
                begin
                    active_next = 1'b1;
                    pos_next    = POS_W'(1);
                    plz_next    = '0;
                    crc_next    = '0;
                    status_c    = ST_COMMAND;
                end
            end
            OP_PAIR:
            begin
                if (active_reg)
                begin
                    pos_next = pos_c;
                    if (head_cmd.true_bit && head_cmd.complement_bit)
                    begin
                        // nobody answered
                        last_disc_next = '0;
                        fam_next       = '0;
                        last_dev_next  = 1'b0;
                        active_next    = 1'b0;
                        status_c       = ST_FAILED;
                    end
                    else
                    begin
                        if (head_cmd.true_bit != head_cmd.complement_bit)
                            dir = head_cmd.true_bit;
                        else
                        begin
                            // discrepancy: follow old path, take 1 at last branch, else 0
                            if (pos_c < last_disc_reg)
                                dir = rom_reg[idx];
                            else
                                dir = (pos_c == last_disc_reg);
                            if (!dir)
                            begin
                                plz_next = pos_c;
                                if (pos_c < POS_W'(FAMILY_LIMIT))
                                    fam_next = pos_c;
                            end
                        end
                        rom_next[idx] = dir;
                        wbit_c        = dir;
                        status_c      = ST_WRITE;
                        if (idx[2:0] == 3'd7)
                            crc_next = crc_byte(crc_reg, rom_next[{idx[5:3], 3'b000} +: 8]);
                        if (pos_c == POS_W'(ROM_BITS))
                        begin
                            active_next = 1'b0;
                            pos_next    = POS_W'(1);
                            if (crc_next == 8'd0 && rom_next[7:0] != 8'd0)
                            begin
                                last_disc_next = plz_next;
                                if (plz_next == '0)
                                    last_dev_next = 1'b1;
                                status_c = ST_FOUND;
                                rom_c    = rom_next;
                                fam_c    = fam_next;
                                last_c   = last_dev_next;
                            end
                            else
                            begin
                                last_disc_next = '0;
                                fam_next       = '0;
                                last_dev_next  = 1'b0;
                                status_c       = ST_FAILED;
                            end
                        end
                        else
                            pos_next = pos_c + POS_W'(1);
                    end
                end
            end
            default:
            begin
                status_c = ST_FAILED;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_reg       <= '0;
            last_disc_reg <= '0;
            fam_reg       <= '0;
            last_dev_reg  <= 1'b0;
            pos_reg       <= POS_W'(1);
            plz_reg       <= '0;
            crc_reg       <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                rom_reg       <= rom_next;
                last_disc_reg <= last_disc_next;
                fam_reg       <= fam_next;
                last_dev_reg  <= last_dev_next;
                pos_reg       <= pos_next;
                plz_reg       <= plz_next;
                crc_reg       <= crc_next;
                active_reg    <= active_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_status_reg <= status_c;
            out_wbit_reg   <= wbit_c;
            out_rom_reg    <= rom_c;
            out_fam_reg    <= fam_c;
            out_last_reg   <= last_c;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {7'd0, out_last_reg, out_fam_reg, out_rom_reg, out_wbit_reg};

endmodule
